// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/pad_pkg.sv =====
// Package with the payload types and codes of the phase-angle dimmer control.
package pad_pkg;

  localparam int SP_BITS = 7;
  localparam int SAMPLE_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 7;

  typedef enum logic [1:0] {
    MODE_PHASE = 2'd0,
    MODE_ON    = 2'd1,
    MODE_OFF   = 2'd2
  } mode_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_ON_BELOW  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_OFF_ABOVE = 2'd1;

  localparam logic [SP_BITS-1:0] FULL_ON_BELOW_RESET  = 7'd1;
  localparam logic [SP_BITS-1:0] FULL_OFF_ABOVE_RESET = 7'd75;

  typedef struct packed {
    logic                   zero_cross_level;
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] pot_sample;
  } tick_t;

  typedef struct packed {
    logic               drive;
    mode_t              mode;
    logic [SP_BITS-1:0] setpoint;
  } result_t;

endpackage

// ===== rtl/pad_filter.sv =====
// Setpoint filter: holds the filtered setpoint and folds in new samples.
module pad_filter
  import pad_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   sample_valid,
  input  logic [SAMPLE_BITS-1:0] pot_sample,
  output logic [SP_BITS-1:0]     setpoint_next
);

  // Sum of half the sample and 31 times the setpoint fits in 12 bits.
  localparam int SUM_BITS = SP_BITS + 5;

  logic [SP_BITS-1:0]  setpoint;
  logic [SUM_BITS-1:0] weighted;
  logic [SUM_BITS-1:0] sum;

  // 31 * sp is formed as 32 * sp - sp.
  assign weighted = {setpoint, 5'd0} - {5'd0, setpoint};
  assign sum = weighted + {{(SUM_BITS-SP_BITS){1'b0}}, pot_sample[SAMPLE_BITS-1:1]};

  always_comb begin
    if (sample_valid) begin
      setpoint_next = sum[SUM_BITS-1:5];
    end else begin
      setpoint_next = setpoint;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
    end else if (step) begin
      setpoint <= setpoint_next;
    end
  end

endmodule

// ===== rtl/pad_phase_ctl.sv =====
// Mode selection, zero-cross edge handling and firing-delay counter.
module pad_phase_ctl
  import pad_pkg::*;
#(
  parameter int COUNTER_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               zero_cross_level,
  input  logic [SP_BITS-1:0] setpoint,
  input  logic [SP_BITS-1:0] full_on_below,
  input  logic [SP_BITS-1:0] full_off_above,
  output logic               drive_next,
  output mode_t              mode_next
);

  logic [COUNTER_BITS-1:0] delay_count;
  logic [COUNTER_BITS-1:0] delay_count_next;
  logic [COUNTER_BITS-1:0] count_inc;
  logic                    counter_running;
  logic                    counter_running_next;
  logic                    last_zero_cross;
  logic                    drive_level;

  assign count_inc = delay_count + {{(COUNTER_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    drive_next = drive_level;
    delay_count_next = delay_count;
    counter_running_next = counter_running;
    priority if (setpoint < full_on_below) begin
      mode_next = MODE_ON;
      drive_next = 1'b1;
      delay_count_next = '0;
    end else if (setpoint > full_off_above) begin
      mode_next = MODE_OFF;
      drive_next = 1'b0;
      delay_count_next = '0;
    end else begin
      mode_next = MODE_PHASE;
      priority if (last_zero_cross && !zero_cross_level) begin
        delay_count_next = '0;
        counter_running_next = 1'b1;
      end else if (!last_zero_cross && zero_cross_level) begin
        drive_next = 1'b0;
        delay_count_next = '0;
        counter_running_next = 1'b0;
      end else if (counter_running) begin
        delay_count_next = count_inc;
        if (count_inc == {{(COUNTER_BITS-SP_BITS){1'b0}}, setpoint}) begin
          drive_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_count <= '0;
      counter_running <= 1'b0;
      last_zero_cross <= 1'b0;
      drive_level <= 1'b0;
    end else if (step) begin
      delay_count <= delay_count_next;
      counter_running <= counter_running_next;
      last_zero_cross <= zero_cross_level;
      drive_level <= drive_next;
    end
  end

endmodule

// ===== rtl/phase_angle_dimmer_control.sv =====
// Top level of the phase-angle triac dimmer control.
//
// Each request on the tick channel (tick_valid, tick_stall, tick) is one tick
// of the prescaled timer: the zero-cross pin level and, when sample_valid is
// set, a new potentiometer sample. Every tick yields exactly one request on
// the result channel (result_valid, result_stall, result) with the gate drive
// level, the mode and the filtered setpoint after that tick.
// A tick is captured in an input register; once the result register is free,
// the filter and the phase logic update their state and the result register
// is loaded. One tick per cycle is taken in steady state while the receiver
// does not stall; the single compute pass between the input register and the
// result register sets that rate. When the receiver stalls, the result
// register holds its request and the input register holds the waiting tick,
// so tick_stall rises only while both are full. Thresholds are written through
// cfg_write, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block does not enforce; unknown indexes are ignored.
// Synchronous reset empties both registers, zeroes the setpoint, stops the
// delay counter, turns the drive off and restores thresholds to 1 and 75.
module phase_angle_dimmer_control
  import pad_pkg::*;
#(
  parameter int COUNTER_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick_valid,
  output logic                      tick_stall,
  input  tick_t                     tick,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  `include "assert_macros.svh"

  // Input register holding one accepted tick.
  logic  pipe_valid;
  tick_t pipe_tick;

  // Threshold registers.
  logic [SP_BITS-1:0] full_on_below;
  logic [SP_BITS-1:0] full_off_above;

  // The compute pass runs when a tick waits and the result register is free.
  logic advance;
  logic step;
  logic tick_accept;

  logic [SP_BITS-1:0] setpoint_next;
  logic               drive_next;
  mode_t              mode_next;

  assign advance = !result_valid || !result_stall;
  assign step = pipe_valid && advance;
  assign tick_stall = pipe_valid && !advance;
  assign tick_accept = tick_valid && !tick_stall;

  pad_filter u_filter (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .sample_valid  (pipe_tick.sample_valid),
    .pot_sample    (pipe_tick.pot_sample),
    .setpoint_next (setpoint_next)
  );

  pad_phase_ctl #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_phase_ctl (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .zero_cross_level (pipe_tick.zero_cross_level),
    .setpoint         (setpoint_next),
    .full_on_below    (full_on_below),
    .full_off_above   (full_off_above),
    .drive_next       (drive_next),
    .mode_next        (mode_next)
  );

  // Handshake control: the input register refills in the same cycle it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      pipe_valid <= tick_accept || (pipe_valid && !advance);
      result_valid <= step || (result_valid && result_stall);
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      pipe_tick <= tick;
    end
    if (step) begin
      result.drive <= drive_next;
      result.mode <= mode_next;
      result.setpoint <= setpoint_next;
    end
  end

  // Configuration writes; any other index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_on_below <= FULL_ON_BELOW_RESET;
      full_off_above <= FULL_OFF_ABOVE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FULL_ON_BELOW) begin
        full_on_below <= cfg_data;
      end
      if (cfg_index == REG_FULL_OFF_ABOVE) begin
        full_off_above <= cfg_data;
      end
    end
  end

  // Full-on mode always reports the gate driven, full-off never.
  `ASSERT_SAME(a_on_drives, clk, rst, result_valid && (result.mode == MODE_ON), result.drive)
  `ASSERT_SAME(a_off_idle, clk, rst, result_valid && (result.mode == MODE_OFF), !result.drive)
  // An empty input register never pushes back on the sender.
  `ASSERT_SAME(a_empty_no_stall, clk, rst, !pipe_valid, !tick_stall)
  // An accepted tick is held in the input register in the next cycle.
  `ASSERT_NEXT(a_accept_held, clk, rst, tick_accept, pipe_valid)
  // A pass through the compute logic always leaves a result request behind.
  `ASSERT_NEXT(a_step_result, clk, rst, step, result_valid)

endmodule
